// File: sv/tc_pkg.sv
// Shared types and widths of the tetrahedron circumsphere pipeline.
// Depends on nothing; tc_cramer, the top level and the checker use it.
`default_nettype none
package tc_pkg;

	localparam int COORD_W = 32;
	// Edge vector components, squares and 2x2 cofactors.
	localparam int DW   = COORD_W + 1;
	localparam int PW   = 2 * DW;
	localparam int CFW  = PW + 1;
	// Half-norm right-hand side (twice, i.e. |d|^2), products and determinants.
	localparam int RW   = 2 * COORD_W + 3;
	localparam int PDW  = DW + CFW;
	localparam int DETW = PDW + 2;
	localparam int PNW  = RW + CFW;
	localparam int NW   = PNW + 2;
	// Wide products are built from halves split at bit SPL, one stage for the
	// partial products and one for their sum.
	localparam int SPL  = 34;
	localparam int CHW  = CFW - SPL;
	localparam int RHW  = RW - SPL;
	localparam int PDHW = DW + CHW;
	localparam int PDLW = DW + SPL + 1;
	localparam int PNHW = RHW + CHW;
	localparam int PNMW = RHW + SPL + 1;
	localparam int PNNW = SPL + 1 + CHW;
	localparam int PNLW = 2 * SPL + 2;
	// Divider operands and quotient bits.
	localparam int NUMW = NW + 1;
	localparam int DENW = DETW + 1;
	localparam int QW   = COORD_W + 3;
	// Square root of the squared offset length.
	localparam int RBW  = COORD_W + 2;
	localparam int SW   = 2 * RBW;

	typedef struct packed {
		logic signed [COORD_W-1:0] p0_x;
		logic signed [COORD_W-1:0] p0_y;
		logic signed [COORD_W-1:0] p0_z;
		logic signed [COORD_W-1:0] p1_x;
		logic signed [COORD_W-1:0] p1_y;
		logic signed [COORD_W-1:0] p1_z;
		logic signed [COORD_W-1:0] p2_x;
		logic signed [COORD_W-1:0] p2_y;
		logic signed [COORD_W-1:0] p2_z;
		logic signed [COORD_W-1:0] p3_x;
		logic signed [COORD_W-1:0] p3_y;
		logic signed [COORD_W-1:0] p3_z;
	} tc_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic        [COORD_W-1:0] radius;
		logic                      found;
		logic                      saturated;
	} tc_out_t;

	// Linear system solved down to divider operands, one set per item.
	typedef struct packed {
		logic                       found;
		logic [2:0]                 neg;
		logic [2:0][NUMW-1:0]       num;
		logic [DENW-1:0]            den;
		logic [2:0][COORD_W-1:0]    p0;
	} tc_sys_t;

endpackage
`default_nettype wire

// File: sv/tc_cramer.sv
// Front end: edge vectors, cofactors, determinant and Cramer numerators.
// Seven register stages; uses tc_pkg for widths and the tc_in_t / tc_sys_t types.
`default_nettype none
module tc_cramer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  tc_pkg::tc_in_t         in_data,
	input  logic [31:0]            thr,
	output logic                   out_valid,
	output tc_pkg::tc_sys_t        sys
);

	function automatic int oth_lo(input int i);
		return (i == 0) ? 1 : 0;
	endfunction

	function automatic int oth_hi(input int i);
		return (i == 2) ? 1 : 2;
	endfunction

	logic signed [tc_pkg::COORD_W-1:0] pin [4][3];
	logic signed [tc_pkg::DW-1:0]      d_s1 [3][3];
	logic signed [tc_pkg::COORD_W-1:0] p0_s1 [3], p0_s2 [3], p0_s3 [3];
	logic signed [tc_pkg::COORD_W-1:0] p0_s4 [3], p0_s5 [3], p0_s6 [3];
	logic signed [tc_pkg::PW-1:0]      sq_s2 [3][3], pa_s2 [3][3], pb_s2 [3][3];
	logic signed [tc_pkg::DW-1:0]      d0_s2 [3], d0_s3 [3];
	logic signed [tc_pkg::RW-1:0]      rhs_s3 [3];
	logic signed [tc_pkg::CFW-1:0]     cof_s3 [3][3];
	logic signed [tc_pkg::PDHW-1:0]    pdh_s4 [3];
	logic signed [tc_pkg::PDLW-1:0]    pdl_s4 [3];
	logic signed [tc_pkg::PNHW-1:0]    pnhh_s4 [3][3];
	logic signed [tc_pkg::PNMW-1:0]    pnhl_s4 [3][3];
	logic signed [tc_pkg::PNNW-1:0]    pnlh_s4 [3][3];
	logic signed [tc_pkg::PNLW-1:0]    pnll_s4 [3][3];
	logic signed [tc_pkg::PDW-1:0]     pd_s5 [3];
	logic signed [tc_pkg::PNW-1:0]     pn_s5 [3][3];
	logic signed [tc_pkg::DETW-1:0]    det_s6;
	logic signed [tc_pkg::NW-1:0]      numr_s6 [3];
	logic [tc_pkg::DETW-1:0]           dm_c;
	logic [tc_pkg::NW-1:0]             nabs_c [3];
	logic [6:0]                        vld_s;
	tc_pkg::tc_sys_t                   sys_s7;

	always_comb begin
		pin[0][0] = in_data.p0_x; pin[0][1] = in_data.p0_y; pin[0][2] = in_data.p0_z;
		pin[1][0] = in_data.p1_x; pin[1][1] = in_data.p1_y; pin[1][2] = in_data.p1_z;
		pin[2][0] = in_data.p2_x; pin[2][1] = in_data.p2_y; pin[2][2] = in_data.p2_z;
		pin[3][0] = in_data.p3_x; pin[3][1] = in_data.p3_y; pin[3][2] = in_data.p3_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[5:0], in_valid};
		end
	end

	always_comb begin
		dm_c = det_s6[tc_pkg::DETW-1] ? $unsigned(-det_s6) : $unsigned(det_s6);
		for (int k = 0; k < 3; k++) begin
			nabs_c[k] = numr_s6[k][tc_pkg::NW-1] ? $unsigned(-numr_s6[k])
			                                     : $unsigned(numr_s6[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p0_s1[k] <= pin[0][k];
				p0_s2[k] <= p0_s1[k];
				p0_s3[k] <= p0_s2[k];
				p0_s4[k] <= p0_s3[k];
				p0_s5[k] <= p0_s4[k];
				p0_s6[k] <= p0_s5[k];
				d0_s2[k] <= d_s1[0][k];
				d0_s3[k] <= d0_s2[k];
				// The cofactor is split in halves; the low half is unsigned.
				pdh_s4[k] <= d0_s3[k]
				           * $signed(cof_s3[0][k][tc_pkg::CFW-1:tc_pkg::SPL]);
				pdl_s4[k] <= d0_s3[k]
				           * $signed({1'b0, cof_s3[0][k][tc_pkg::SPL-1:0]});
				pd_s5[k]  <= (tc_pkg::PDW'(pdh_s4[k]) <<< tc_pkg::SPL)
				           + tc_pkg::PDW'(pdl_s4[k]);
			end
			for (int i = 0; i < 3; i++) begin
				rhs_s3[i] <= tc_pkg::RW'(sq_s2[i][0]) + tc_pkg::RW'(sq_s2[i][1])
				           + tc_pkg::RW'(sq_s2[i][2]);
				for (int k = 0; k < 3; k++) begin
					d_s1[i][k]  <= tc_pkg::DW'(pin[i+1][k]) - tc_pkg::DW'(pin[0][k]);
					sq_s2[i][k] <= d_s1[i][k] * d_s1[i][k];
					pa_s2[i][k] <= d_s1[oth_lo(i)][oth_lo(k)] * d_s1[oth_hi(i)][oth_hi(k)];
					pb_s2[i][k] <= d_s1[oth_lo(i)][oth_hi(k)] * d_s1[oth_hi(i)][oth_lo(k)];
					// Odd positions of the cofactor checkerboard take the minus sign.
					if (((i + k) & 1) == 1) begin
						cof_s3[i][k] <= tc_pkg::CFW'(pb_s2[i][k]) - tc_pkg::CFW'(pa_s2[i][k]);
					end else begin
						cof_s3[i][k] <= tc_pkg::CFW'(pa_s2[i][k]) - tc_pkg::CFW'(pb_s2[i][k]);
					end
					pnhh_s4[i][k] <= $signed(rhs_s3[i][tc_pkg::RW-1:tc_pkg::SPL])
					               * $signed(cof_s3[i][k][tc_pkg::CFW-1:tc_pkg::SPL]);
					pnhl_s4[i][k] <= $signed(rhs_s3[i][tc_pkg::RW-1:tc_pkg::SPL])
					               * $signed({1'b0, cof_s3[i][k][tc_pkg::SPL-1:0]});
					pnlh_s4[i][k] <= $signed({1'b0, rhs_s3[i][tc_pkg::SPL-1:0]})
					               * $signed(cof_s3[i][k][tc_pkg::CFW-1:tc_pkg::SPL]);
					pnll_s4[i][k] <= $signed({1'b0, rhs_s3[i][tc_pkg::SPL-1:0]})
					               * $signed({1'b0, cof_s3[i][k][tc_pkg::SPL-1:0]});
					pn_s5[i][k]   <= (tc_pkg::PNW'(pnhh_s4[i][k]) <<< (2 * tc_pkg::SPL))
					               + ((tc_pkg::PNW'(pnhl_s4[i][k])
					                 + tc_pkg::PNW'(pnlh_s4[i][k])) <<< tc_pkg::SPL)
					               + tc_pkg::PNW'(pnll_s4[i][k]);
				end
			end
			det_s6 <= tc_pkg::DETW'(pd_s5[0]) + tc_pkg::DETW'(pd_s5[1])
			        + tc_pkg::DETW'(pd_s5[2]);
			for (int k = 0; k < 3; k++) begin
				numr_s6[k] <= tc_pkg::NW'(pn_s5[0][k]) + tc_pkg::NW'(pn_s5[1][k])
				            + tc_pkg::NW'(pn_s5[2][k]);
			end
			sys_s7.found <= dm_c > tc_pkg::DETW'(thr);
			sys_s7.den   <= {dm_c, 1'b0};
			for (int k = 0; k < 3; k++) begin
				sys_s7.neg[k] <= numr_s6[k][tc_pkg::NW-1] ^ det_s6[tc_pkg::DETW-1];
				sys_s7.num[k] <= tc_pkg::NUMW'(nabs_c[k]) + tc_pkg::NUMW'(dm_c);
				sys_s7.p0[k]  <= p0_s6[k];
			end
		end
	end

	assign out_valid = vld_s[6];
	assign sys       = sys_s7;

endmodule
`default_nettype wire

// File: sv/tc_div.sv
// Pipelined restoring divider: one quotient bit per stage, with an overflow check.
// Stand-alone apart from tc_pkg conventions; instanced once per centre axis.
`default_nettype none
module tc_div #(
	parameter int NUMW = 137,
	parameter int DENW = 103,
	parameter int QW   = 35,
	parameter int TW   = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	input  logic [TW-1:0]   tag_in,
	output logic            out_valid,
	output logic [QW-1:0]   quo,
	output logic            ovf,
	output logic [TW-1:0]   tag_out
);

	localparam int CW = DENW + QW;

	logic [CW-1:0]   rem_s [QW];
	logic [DENW-1:0] den_s [QW];
	logic [QW-1:0]   quo_s [QW+1];
	logic            ovf_s [QW+1];
	logic [TW-1:0]   tag_s [QW+1];
	logic [QW:0]     vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-1:0], in_valid};
		end
	end

	// A quotient of 2^QW or more cannot be represented; it is flagged here.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num);
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= CW'(num) >= {den, {QW{1'b0}}};
			tag_s[0] <= tag_in;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_stage
		localparam int B = QW - j;
		logic [CW-1:0] trial;
		logic          ge;

		assign trial = CW'(den_s[j-1]) << B;
		assign ge    = rem_s[j-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j]    <= quo_s[j-1] | (QW'(ge) << B);
				ovf_s[j]    <= ovf_s[j-1];
				tag_s[j]    <= tag_s[j-1];
			end
		end

		if (j < QW) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= ge ? rem_s[j-1] - trial : rem_s[j-1];
					den_s[j] <= den_s[j-1];
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = quo_s[QW];
	assign ovf       = ovf_s[QW];
	assign tag_out   = tag_s[QW];

endmodule
`default_nettype wire

// File: sv/tc_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage, rounded to nearest.
// Stand-alone; used by the top level for the radius.
`default_nettype none
module tc_sqrt #(
	parameter int SW  = 68,
	parameter int RBW = 34,
	parameter int TW  = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [SW-1:0]  sq,
	input  logic [TW-1:0]  tag_in,
	output logic           out_valid,
	output logic [RBW:0]   root,
	output logic [TW-1:0]  tag_out
);

	localparam int CW = SW + 1;

	logic [SW-1:0]  rem_s [RBW];
	logic [RBW-1:0] rt_s  [RBW];
	logic [TW-1:0]  tag_s [RBW+1];
	logic [RBW:0]   vld_s;
	logic [RBW:0]   root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[RBW-1:0], in_valid};
		end
	end

	for (genvar j = 0; j < RBW; j++) begin : g_stage
		localparam int B = RBW - 1 - j;
		logic [SW-1:0]  rem_prev;
		logic [RBW-1:0] rt_prev;
		logic [TW-1:0]  tag_prev;
		logic [CW-1:0]  trial;
		logic           ge;

		if (j == 0) begin : g_first
			assign rem_prev = sq;
			assign rt_prev  = '0;
			assign tag_prev = tag_in;
		end else begin : g_next
			assign rem_prev = rem_s[j-1];
			assign rt_prev  = rt_s[j-1];
			assign tag_prev = tag_s[j-1];
		end

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign trial = (CW'(rt_prev) << (B + 1)) + (CW'(1) << (2 * B));
		assign ge    = CW'(rem_prev) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]    <= ge ? rem_prev - trial[SW-1:0] : rem_prev;
				rt_s[j]     <= rt_prev | (RBW'(ge) << B);
				tag_s[j]    <= tag_prev;
			end
		end
	end

	// Round up when the square exceeds r^2 + r, that is when the remainder exceeds r.
	always_ff @(posedge clk) begin
		if (en) begin
			root_q     <= (RBW+1)'(rt_s[RBW-1])
			            + (RBW+1)'(rem_s[RBW-1] > SW'(rt_s[RBW-1]));
			tag_s[RBW] <= tag_s[RBW-1];
		end
	end

	assign out_valid = vld_s[RBW];
	assign root      = root_q;
	assign tag_out   = tag_s[RBW];

endmodule
`default_nettype wire

// File: sv/tetrahedron_circumsphere.sv
// Circumsphere of a tetrahedron: top level joining the Cramer front end,
// the three dividers and the square root. Uses tc_pkg, tc_cramer, tc_div, tc_sqrt.
//
// Usage: an item of four vertices enters on in_valid/in_stall (in_data) and one
// result leaves on out_valid/out_stall (out_data) with the centre, the radius,
// the found flag and the saturated flag. One item can enter every clock cycle
// while in_stall is low. Items pass the edge matrix and determinants, the
// bit-per-stage dividers (one overflow check plus 35 quotient bits), the
// centre and squared length, the square root and one output register.
// The singular threshold is written through cfg_wr_en/cfg_wr_data; reset sets
// it to zero. Write it only while no item is in flight.
// Reset empties the pipeline and drops out_valid; the threshold returns to zero.
// While out_valid is high and out_stall is high the whole pipeline holds,
// in_stall rises, and the waiting result stays unchanged on out_data.
`default_nettype none
module tetrahedron_circumsphere (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tc_pkg::tc_in_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output tc_pkg::tc_out_t out_data,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data
);

	localparam int W   = tc_pkg::COORD_W;
	localparam int TW0 = 3 * W + 2;
	localparam int STW = 3 * W + 2;
	localparam logic [W+1:0]        LIM  = {1'b1, {(W+1){1'b0}}};
	localparam logic signed [W+3:0] CMAX = $signed({5'b00000, {(W-1){1'b1}}});
	localparam logic signed [W+3:0] CMIN = $signed({5'b11111, {(W-1){1'b0}}});

	logic                    en;
	logic [31:0]             thr_q;
	logic                    cr_valid;
	tc_pkg::tc_sys_t         sys;
	logic                    dv_valid;
	logic [tc_pkg::QW-1:0]   quo [3];
	logic                    ovf [3];
	logic [TW0-1:0]          tag0;
	logic                    neg1, neg2;
	logic [W+1:0]            qm_c [3];
	logic signed [W+2:0]     qs_c [3];
	logic signed [W-1:0]     p0_c [3];
	logic                    v_s1, v_s2;
	logic [tc_pkg::SW-1:0]   sq_s1 [3];
	logic signed [W+3:0]     csum_s1 [3];
	logic                    found_s1;
	logic [tc_pkg::SW-1:0]   ssum_s2;
	logic [2:0][W-1:0]       cen_s2;
	logic                    satc_s2, found_s2;
	logic                    sr_valid;
	logic [tc_pkg::RBW:0]    root;
	logic [STW-1:0]          stag;
	logic                    ov_q;
	tc_pkg::tc_out_t         out_q;
	logic                    rsat_c;

	assign en       = !(ov_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	tc_cramer u_cramer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.thr       (thr_q),
		.out_valid (cr_valid),
		.sys       (sys)
	);

	tc_div #(.NUMW(tc_pkg::NUMW), .DENW(tc_pkg::DENW), .QW(tc_pkg::QW), .TW(TW0)) u_div0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cr_valid),
		.num(sys.num[0]), .den(sys.den), .tag_in({sys.found, sys.neg[0], sys.p0}),
		.out_valid(dv_valid), .quo(quo[0]), .ovf(ovf[0]), .tag_out(tag0)
	);

	tc_div #(.NUMW(tc_pkg::NUMW), .DENW(tc_pkg::DENW), .QW(tc_pkg::QW), .TW(1)) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cr_valid),
		.num(sys.num[1]), .den(sys.den), .tag_in(sys.neg[1]),
		.out_valid(), .quo(quo[1]), .ovf(ovf[1]), .tag_out(neg1)
	);

	tc_div #(.NUMW(tc_pkg::NUMW), .DENW(tc_pkg::DENW), .QW(tc_pkg::QW), .TW(1)) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(cr_valid),
		.num(sys.num[2]), .den(sys.den), .tag_in(sys.neg[2]),
		.out_valid(), .quo(quo[2]), .ovf(ovf[2]), .tag_out(neg2)
	);

	// Offsets are clamped to 2^(W+1), enough to saturate centre and radius alike.
	always_comb begin
		p0_c[0] = $signed(tag0[W-1:0]);
		p0_c[1] = $signed(tag0[2*W-1:W]);
		p0_c[2] = $signed(tag0[3*W-1:2*W]);
		for (int k = 0; k < 3; k++) begin
			qm_c[k] = (ovf[k] || quo[k] > tc_pkg::QW'(LIM)) ? LIM : quo[k][W+1:0];
		end
		qs_c[0] = tag0[3*W] ? -$signed({1'b0, qm_c[0]}) : $signed({1'b0, qm_c[0]});
		qs_c[1] = neg1      ? -$signed({1'b0, qm_c[1]}) : $signed({1'b0, qm_c[1]});
		qs_c[2] = neg2      ? -$signed({1'b0, qm_c[2]}) : $signed({1'b0, qm_c[2]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= dv_valid;
			v_s2 <= v_s1;
			ov_q <= sr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k]   <= tc_pkg::SW'(qm_c[k]) * tc_pkg::SW'(qm_c[k]);
				csum_s1[k] <= (W+4)'(p0_c[k]) + (W+4)'(qs_c[k]);
			end
			found_s1 <= tag0[3*W+1];
			ssum_s2  <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			found_s2 <= found_s1;
			satc_s2  <= (csum_s1[0] > CMAX) || (csum_s1[0] < CMIN)
			         || (csum_s1[1] > CMAX) || (csum_s1[1] < CMIN)
			         || (csum_s1[2] > CMAX) || (csum_s1[2] < CMIN);
			for (int k = 0; k < 3; k++) begin
				if (csum_s1[k] > CMAX) begin
					cen_s2[k] <= CMAX[W-1:0];
				end else if (csum_s1[k] < CMIN) begin
					cen_s2[k] <= CMIN[W-1:0];
				end else begin
					cen_s2[k] <= csum_s1[k][W-1:0];
				end
			end
		end
	end

	tc_sqrt #(.SW(tc_pkg::SW), .RBW(tc_pkg::RBW), .TW(STW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.sq(ssum_s2), .tag_in({found_s2, satc_s2, cen_s2}),
		.out_valid(sr_valid), .root(root), .tag_out(stag)
	);

	assign rsat_c = |root[tc_pkg::RBW:W];

	// A singular system gives an all-zero item with both flags clear.
	always_ff @(posedge clk) begin
		if (en) begin
			if (stag[3*W+1]) begin
				out_q.center_x  <= $signed(stag[W-1:0]);
				out_q.center_y  <= $signed(stag[2*W-1:W]);
				out_q.center_z  <= $signed(stag[3*W-1:2*W]);
				out_q.radius    <= rsat_c ? {W{1'b1}} : root[W-1:0];
				out_q.found     <= 1'b1;
				out_q.saturated <= stag[3*W] || rsat_c;
			end else begin
				out_q <= '0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// File: sv/tc_checker.sv
// Port-level checks of the circumsphere block, bound to its top level.
// Uses tc_pkg for the result type.
`default_nettype none
module tc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input tc_pkg::tc_out_t out_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item withdrawn while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result item changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> in_stall == (out_valid && out_stall))
		else $error("input stall does not follow a blocked output");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.center_x == 0 && out_data.center_y == 0
		&& out_data.center_z == 0 && out_data.radius == 0 && !out_data.saturated)
		else $error("singular item carries non-zero fields");

endmodule

bind tetrahedron_circumsphere tc_checker u_tc_checker (.*);
`default_nettype wire
